[rtl/smm_pkg.sv]
// Shared constants, types and codes for the square matrix multiply core.
package smm_pkg;

  // Largest matrix dimension held by the element stores.
  localparam int MAX_DIM = 64;
  // Width of one stored element (signed Q8.8 at the default width).
  localparam int ELEM_BITS = 16;

  // Fixed field widths of the request and result channels.
  localparam int MODE_BITS = 2;
  localparam int IDX_BITS = 6;
  localparam int IN_VALUE_BITS = 16;
  localparam int SIZE_BITS = 7;
  localparam int ACC_BITS = 38;

  // Derived widths.
  localparam int ADDR_BITS = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_BITS = $clog2(MAX_DIM + 1);
  localparam int PROD_BITS = 2 * ELEM_BITS;

  // Stream and configuration port widths.
  localparam int IN_DATA_BITS = 32;
  localparam int OUT_DATA_BITS = 56;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Reset value of the size register.
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(50);

  // Request kinds carried on tuser.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_WR_A  = 2'd0,
    MODE_WR_B  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_SIZE = 1'b0
  } reg_idx_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic vld;
    logic zero;
  } mac_ctl_t;

endpackage

[rtl/square_matrix_multiply_core.sv]
// A query walks n = min(size_in_use, 64) element pairs through the single
// multiply-accumulate unit, reading the one read port of each element store. Write requests
// are taken every cycle while no query is in progress; a query holds the input until its
// result is loaded into the output register. A finished result waits in an output
// register; a second finished result holds the input until that register frees.
// Synchronous reset clears control state and sets size_in_use to 50; stores are not cleared.
module square_matrix_multiply_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: row[5:0], col[11:6], element_value[27:12], zero[31:28]
  input  logic [smm_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // in_tuser: mode[1:0]
  input  logic [smm_pkg::MODE_BITS-1:0]       in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: product_value[37:0], product_row[43:38], product_col[49:44],
  // zero[55:50]
  output logic [smm_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [smm_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [smm_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [smm_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Request fields.
  logic [smm_pkg::IDX_BITS-1:0]             in_row;
  logic [smm_pkg::IDX_BITS-1:0]             in_col;
  logic signed [smm_pkg::IN_VALUE_BITS-1:0] in_value;
  smm_pkg::mode_t                           in_mode;
  logic                                     in_acc;
  logic                                     in_row_ok;
  logic                                     in_col_ok;

  // Configuration.
  logic [smm_pkg::SIZE_BITS-1:0] size_r;
  logic [smm_pkg::CNT_BITS-1:0]  size_sat;

  // Query context.
  logic [smm_pkg::IDX_BITS-1:0] row_r, row_nxt;
  logic [smm_pkg::IDX_BITS-1:0] col_r, col_nxt;
  logic                         zero_r, zero_nxt;
  logic [smm_pkg::CNT_BITS-1:0] n_r, n_nxt;
  logic [smm_pkg::CNT_BITS-1:0] k_r, k_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         issue;
  logic                         run_end;

  // Store ports.
  logic                                 we_a, we_b;
  logic [smm_pkg::ADDR_BITS-1:0]        waddr;
  logic signed [smm_pkg::ELEM_BITS-1:0] wdata;
  logic [smm_pkg::ADDR_BITS-1:0]        raddr_a, raddr_b;
  logic signed [smm_pkg::ELEM_BITS-1:0] rdata_a, rdata_b;

  // Multiply-accumulate unit.
  smm_pkg::mac_ctl_t                    mac_ctl;
  logic signed [smm_pkg::ACC_BITS-1:0]  acc;
  logic                                 mac_busy;

  // Output register.
  logic                                 out_vld_r, out_vld_nxt;
  logic signed [smm_pkg::ACC_BITS-1:0]  out_value_r, out_value_nxt;
  logic [smm_pkg::IDX_BITS-1:0]         out_row_r, out_row_nxt;
  logic [smm_pkg::IDX_BITS-1:0]         out_col_r, out_col_nxt;
  logic                                 out_load;

  // Unpack the request.
  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[27:12];
  assign in_mode  = smm_pkg::mode_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_row_ok = (32'(in_row) < smm_pkg::MAX_DIM);
  assign in_col_ok = (32'(in_col) < smm_pkg::MAX_DIM);

  smm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .size_r      (size_r)
  );

  // Size saturates at the store dimension.
  assign size_sat = (32'(size_r) > smm_pkg::MAX_DIM) ?
                    smm_pkg::CNT_BITS'(smm_pkg::MAX_DIM) :
                    smm_pkg::CNT_BITS'(size_r);

  // Element writes go straight to the stores on the accepting edge.
  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    if (in_acc && in_row_ok && in_col_ok) begin
      case (in_mode)
        smm_pkg::MODE_WR_A: we_a = 1'b1;
        smm_pkg::MODE_WR_B: we_b = 1'b1;
        default: begin
          we_a = 1'b0;
          we_b = 1'b0;
        end
      endcase
    end
  end

  assign waddr = smm_pkg::ADDR_BITS'(32'(in_row) * smm_pkg::MAX_DIM + 32'(in_col));
  assign wdata = smm_pkg::ELEM_BITS'(in_value);

  // Walk row of A and column of B, one element pair per cycle.
  assign issue   = (state_r == ST_RUN) && (k_r < n_r);
  assign raddr_a = smm_pkg::ADDR_BITS'(32'(row_r) * smm_pkg::MAX_DIM + 32'(k_r));
  assign raddr_b = smm_pkg::ADDR_BITS'(32'(k_r) * smm_pkg::MAX_DIM + 32'(col_r));
  assign run_end = (k_r == n_r) && !rd_vld_r && !mac_busy;

  smm_store u_store_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr_a),
    .rdata_r (rdata_a)
  );

  smm_store u_store_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr_b),
    .rdata_r (rdata_b)
  );

  // The accumulator clears when a query is taken.
  always_comb begin
    mac_ctl.clear = in_acc && (in_mode == smm_pkg::MODE_QUERY);
    mac_ctl.vld   = rd_vld_r;
    mac_ctl.zero  = zero_r;
  end

  smm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_in  (rdata_a),
    .b_in  (rdata_b),
    .acc_r (acc),
    .busy  (mac_busy)
  );

  // Sequencer.
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    zero_nxt   = zero_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    rd_vld_nxt = issue;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == smm_pkg::MODE_QUERY) begin
          row_nxt   = in_row;
          col_nxt   = in_col;
          zero_nxt  = !(in_row_ok && in_col_ok);
          n_nxt     = size_sat;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          k_nxt = k_r + 1'b1;
        end else if (run_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      k_r      <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      k_r      <= k_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    zero_r <= zero_nxt;
  end

  // Output register: holds a result until the consumer takes it.
  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt   = 1'b1;
      out_value_nxt = acc;
      out_row_nxt   = row_r;
      out_col_nxt   = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_col_r, out_row_r, out_value_r};

  // The element counter never passes the latched size.
  a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= n_r)
    else $error("element counter passed the size");

  // The latched size never exceeds the store dimension.
  a_n_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_r) <= smm_pkg::MAX_DIM)
    else $error("latched size above store dimension");

  // A taken query starts the walk on the next cycle.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == smm_pkg::MODE_QUERY) |=> (state_r == ST_RUN))
    else $error("query did not start the walk");

  // Store reads are in flight only once issued during the walk.
  a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_RUN))
    else $error("read in flight outside the walk");

  // The result is loaded only once the accumulator has drained.
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!rd_vld_r && !mac_busy))
    else $error("result loaded before accumulation finished");

endmodule

[rtl/smm_cfg.sv]
// APB-style configuration register block holding the matrix size in use.
module smm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [smm_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [smm_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [smm_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready,
  output logic [smm_pkg::SIZE_BITS-1:0]       size_r
);

  logic [smm_pkg::SIZE_BITS-1:0] size_nxt;
  logic                          wr_en;
  smm_pkg::reg_idx_t             reg_idx;

  // Registers sit on 4-byte boundaries; the word index selects one.
  assign reg_idx    = smm_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Next value of the size register.
  always_comb begin
    size_nxt = size_r;
    if (wr_en && reg_idx == smm_pkg::REG_SIZE) begin
      size_nxt = cfg_pwdata[smm_pkg::SIZE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= smm_pkg::SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      smm_pkg::REG_SIZE: cfg_prdata = smm_pkg::CFG_DATA_BITS'(size_r);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/smm_store.sv]
// One matrix element store: single write port, single registered read port.
module smm_store (
  input  logic                                clk,
  input  logic                                we,
  input  logic [smm_pkg::ADDR_BITS-1:0]       waddr,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] wdata,
  input  logic [smm_pkg::ADDR_BITS-1:0]       raddr,
  output logic signed [smm_pkg::ELEM_BITS-1:0] rdata_r
);

  logic signed [smm_pkg::ELEM_BITS-1:0] mem [smm_pkg::MAX_DIM * smm_pkg::MAX_DIM];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

[rtl/smm_mac.sv]
// Shared multiply-accumulate unit: registered product, then exact accumulation.
module smm_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smm_pkg::mac_ctl_t                    ctl,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] a_in,
  input  logic signed [smm_pkg::ELEM_BITS-1:0] b_in,
  output logic signed [smm_pkg::ACC_BITS-1:0]  acc_r,
  output logic                                 busy
);

  logic signed [smm_pkg::PROD_BITS-1:0] mul_full;
  logic signed [smm_pkg::PROD_BITS-1:0] prod_r;
  logic signed [smm_pkg::PROD_BITS-1:0] prod_nxt;
  logic                                 prod_vld_r;
  logic signed [smm_pkg::ACC_BITS-1:0]  acc_nxt;

  // Multiply stage; the signed product is formed on its own so both operands
  // sign-extend. An out-of-range operand contributes nothing.
  assign mul_full = a_in * b_in;
  assign prod_nxt = ctl.zero ? '0 : mul_full;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.vld;
    end
  end

  // Accumulate stage.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + smm_pkg::ACC_BITS'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign busy = prod_vld_r;

endmodule
